@@ hdl/middle_insert_queue_core_defines.svh @@
// assertion macros for the middle insert queue
`ifndef MIDDLE_INSERT_QUEUE_CORE_DEFINES_SVH
`define MIDDLE_INSERT_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MIQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MIQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/miq_pkg.sv @@
// shared constants for the middle insert queue
`timescale 1ns / 1ps
package miq_pkg;

  localparam int KIND_W   = 2;
  localparam int IN_IDENT_W = 16;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 3;

  localparam int DEF_HALF_DEPTH  = 512;
  localparam int DEF_IDENT_WIDTH = 16;

  localparam logic [KIND_W-1:0] KIND_TAIL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MID  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH     = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE     = 3'd2;
  localparam logic [OP_W-1:0] OP_POP      = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_FILL = 3'd4;
  localparam logic [OP_W-1:0] OP_FULL     = 3'd5;
  localparam logic [OP_W-1:0] OP_EMPTY    = 3'd6;

endpackage

@@ hdl/miq_if.sv @@
// request and result channel interfaces
`timescale 1ns / 1ps
interface miq_in_if;
  logic                            valid;
  logic                            ready;
  logic [miq_pkg::KIND_W-1:0]      kind;
  logic [miq_pkg::IN_IDENT_W-1:0]  ident;

  modport source (output valid, output kind, output ident, input ready);
  modport sink   (input valid, input kind, input ident, output ready);
endinterface

interface miq_out_if;
  logic                            valid;
  logic                            ready;
  logic [miq_pkg::IN_IDENT_W-1:0]  popped_ident;
  logic [miq_pkg::STATUS_W-1:0]    status;

  modport source (output valid, output popped_ident, output status, input ready);
  modport sink   (input valid, input popped_ident, input status, output ready);
endinterface

@@ hdl/miq_ram.sv @@
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module miq_ram #(
  parameter int WIDTH = miq_pkg::DEF_IDENT_WIDTH,
  parameter int DEPTH = miq_pkg::DEF_HALF_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/miq_ctrl.sv @@
// request sequencer, half queue pointers and result register
`timescale 1ns / 1ps
module miq_ctrl #(
  parameter int HALF_DEPTH  = miq_pkg::DEF_HALF_DEPTH,
  parameter int IDENT_WIDTH = miq_pkg::DEF_IDENT_WIDTH,
  localparam int AW = $clog2(HALF_DEPTH),
  localparam int CW = $clog2(HALF_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  miq_in_if.sink                 in_chan,
  miq_out_if.source              out_chan,
  output logic                   f_we,
  output logic [AW-1:0]          f_waddr,
  output logic [IDENT_WIDTH-1:0] f_wdata,
  output logic                   f_re,
  output logic [AW-1:0]          f_raddr,
  input  logic [IDENT_WIDTH-1:0] f_rdata,
  output logic                   b_we,
  output logic [AW-1:0]          b_waddr,
  output logic [IDENT_WIDTH-1:0] b_wdata,
  output logic                   b_re,
  output logic [AW-1:0]          b_raddr,
  input  logic [IDENT_WIDTH-1:0] b_rdata,
  output logic [CW-1:0]          front_count,
  output logic [CW-1:0]          back_count
);

  localparam int SW = AW + 1;
  localparam int TW = CW + 1;
  localparam int IW = miq_pkg::IN_IDENT_W;
  localparam int XW = (IDENT_WIDTH > IW) ? IDENT_WIDTH : IW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [miq_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [AW-1:0]                wa_r, wa_nxt;
  logic [AW-1:0]                fh_r, fh_nxt;
  logic [AW-1:0]                bh_r, bh_nxt;
  logic [CW-1:0]                fc_r, fc_nxt;
  logic [CW-1:0]                bc_r, bc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [IW-1:0]                out_ident_r, out_ident_nxt;
  logic [miq_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                         accept;
  logic                         out_free;
  logic                         full;
  logic                         has_res;
  logic                         load;
  logic [AW-1:0]                f_tail;
  logic [AW-1:0]                b_tail;
  logic [XW-1:0]                id_x;
  logic [IDENT_WIDTH-1:0]       id_s;
  logic [XW-1:0]                pop_x;
  logic [IW-1:0]                res_ident;
  logic [miq_pkg::STATUS_W-1:0] res_status;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(c);
    if (s >= SW'(HALF_DEPTH)) begin
      s = s - SW'(HALF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(HALF_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(HALF_DEPTH - 1) : p - AW'(1);
  endfunction

  assign accept   = in_chan.valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_chan.ready;
  assign full     = (TW'(fc_r) + TW'(bc_r)) >= TW'(2 * HALF_DEPTH);
  assign f_tail   = wrap_add(fh_r, fc_r);
  assign b_tail   = wrap_add(bh_r, bc_r);
  assign id_x     = XW'(in_chan.ident);
  assign id_s     = id_x[IDENT_WIDTH-1:0];
  assign pop_x    = XW'(f_rdata);

  always_comb begin
    case (op_r) inside
      miq_pkg::OP_POP, miq_pkg::OP_POP_FILL: begin
        has_res    = 1'b1;
        res_ident  = pop_x[IW-1:0];
        res_status = miq_pkg::STATUS_OK;
      end
      miq_pkg::OP_FULL: begin
        has_res    = 1'b1;
        res_ident  = '0;
        res_status = miq_pkg::STATUS_FULL;
      end
      miq_pkg::OP_EMPTY: begin
        has_res    = 1'b1;
        res_ident  = '0;
        res_status = miq_pkg::STATUS_EMPTY;
      end
      default: begin
        has_res    = 1'b0;
        res_ident  = '0;
        res_status = miq_pkg::STATUS_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    wa_nxt         = wa_r;
    fh_nxt         = fh_r;
    bh_nxt         = bh_r;
    fc_nxt         = fc_r;
    bc_nxt         = bc_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_ident_nxt  = out_ident_r;
    out_status_nxt = out_status_r;
    load           = 1'b0;
    f_we    = 1'b0;
    f_waddr = f_tail;
    f_wdata = id_s;
    f_re    = 1'b0;
    f_raddr = fh_r;
    b_we    = 1'b0;
    b_waddr = b_tail;
    b_wdata = id_s;
    b_re    = 1'b0;
    b_raddr = bh_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          wa_nxt    = f_tail;
          state_nxt = ST_WRITE;
          unique case (in_chan.kind)
            miq_pkg::KIND_TAIL: begin
              if (full) begin
                op_nxt = miq_pkg::OP_FULL;
              end else if (bc_r == fc_r) begin
                fc_nxt = fc_r + CW'(1);
                if (bc_r == '0) begin
                  f_we   = 1'b1;
                  op_nxt = miq_pkg::OP_PUSH;
                end else begin
                  b_re   = 1'b1;
                  b_we   = 1'b1;
                  bh_nxt = ptr_inc(bh_r);
                  op_nxt = miq_pkg::OP_MOVE;
                end
              end else begin
                b_we   = 1'b1;
                bc_nxt = bc_r + CW'(1);
                op_nxt = miq_pkg::OP_PUSH;
              end
            end
            miq_pkg::KIND_MID: begin
              if (full) begin
                op_nxt = miq_pkg::OP_FULL;
              end else if (TW'(fc_r) == TW'(bc_r) + TW'(1)) begin
                b_we    = 1'b1;
                b_waddr = ptr_dec(bh_r);
                bh_nxt  = ptr_dec(bh_r);
                bc_nxt  = bc_r + CW'(1);
                op_nxt  = miq_pkg::OP_PUSH;
              end else begin
                f_we   = 1'b1;
                fc_nxt = fc_r + CW'(1);
                op_nxt = miq_pkg::OP_PUSH;
              end
            end
            miq_pkg::KIND_POP: begin
              if (fc_r == '0) begin
                op_nxt = miq_pkg::OP_EMPTY;
              end else begin
                f_re   = 1'b1;
                fh_nxt = ptr_inc(fh_r);
                if (bc_r == fc_r) begin
                  b_re   = 1'b1;
                  bh_nxt = ptr_inc(bh_r);
                  bc_nxt = bc_r - CW'(1);
                  op_nxt = miq_pkg::OP_POP_FILL;
                end else begin
                  fc_nxt = fc_r - CW'(1);
                  op_nxt = miq_pkg::OP_POP;
                end
              end
            end
            default: begin
              op_nxt = miq_pkg::OP_NONE;
            end
          endcase
        end
      end
      ST_WRITE: begin
        if ((op_r == miq_pkg::OP_MOVE) || (op_r == miq_pkg::OP_POP_FILL)) begin
          f_we    = 1'b1;
          f_waddr = wa_r;
          f_wdata = b_rdata;
        end
        if (!has_res) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt  = 1'b1;
      out_ident_nxt  = res_ident;
      out_status_nxt = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= miq_pkg::OP_NONE;
      fh_r        <= '0;
      bh_r        <= '0;
      fc_r        <= '0;
      bc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      fh_r        <= fh_nxt;
      bh_r        <= bh_nxt;
      fc_r        <= fc_nxt;
      bc_r        <= bc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wa_r         <= wa_nxt;
    out_ident_r  <= out_ident_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_ident = out_ident_r;
  assign out_chan.status       = out_status_r;
  assign front_count           = fc_r;
  assign back_count            = bc_r;

endmodule

@@ hdl/middle_insert_queue_core.sv @@
// a request is taken in the idle state; its result is loaded in the write state, or in hold while the output is busy
// a new request is taken only back in idle, after the write state in which the front store write back happens
// a result waiting at the output holds the sequencer until taken; inputs stall meanwhile
// reset clears the head pointers, fill counts, sequencer and output valid at once
// store contents are undefined after reset and never read before written, no clearing pass
`timescale 1ns / 1ps
`include "middle_insert_queue_core_defines.svh"
module middle_insert_queue_core #(
  parameter int HALF_DEPTH  = miq_pkg::DEF_HALF_DEPTH,
  parameter int IDENT_WIDTH = miq_pkg::DEF_IDENT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  miq_in_if.sink    in_chan,
  miq_out_if.source out_chan
);

  localparam int AW = $clog2(HALF_DEPTH);
  localparam int CW = $clog2(HALF_DEPTH + 1);
  localparam int TW = CW + 1;

  logic                   f_we, f_re, b_we, b_re;
  logic [AW-1:0]          f_waddr, f_raddr, b_waddr, b_raddr;
  logic [IDENT_WIDTH-1:0] f_wdata, f_rdata, b_wdata, b_rdata;
  logic [CW-1:0]          fc, bc;

  miq_ctrl #(
    .HALF_DEPTH  (HALF_DEPTH),
    .IDENT_WIDTH (IDENT_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .f_we        (f_we),
    .f_waddr     (f_waddr),
    .f_wdata     (f_wdata),
    .f_re        (f_re),
    .f_raddr     (f_raddr),
    .f_rdata     (f_rdata),
    .b_we        (b_we),
    .b_waddr     (b_waddr),
    .b_wdata     (b_wdata),
    .b_re        (b_re),
    .b_raddr     (b_raddr),
    .b_rdata     (b_rdata),
    .front_count (fc),
    .back_count  (bc)
  );

  // front half store, head of the queue
  miq_ram #(
    .WIDTH (IDENT_WIDTH),
    .DEPTH (HALF_DEPTH)
  ) u_front_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // back half store, tail of the queue
  miq_ram #(
    .WIDTH (IDENT_WIDTH),
    .DEPTH (HALF_DEPTH)
  ) u_back_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  `MIQ_ASSERT_IMP(a_half_balance, 1'b1, (fc == bc) || (TW'(fc) == TW'(bc) + TW'(1)), "halves out of balance")
  `MIQ_ASSERT_IMP(a_front_bound, 1'b1, TW'(fc) <= TW'(HALF_DEPTH), "front half overfilled")
  `MIQ_ASSERT_NXT(a_busy_after_req, in_chan.valid && in_chan.ready, !in_chan.ready, "request taken while busy")

endmodule

@@ tb/tb_middle_insert_queue_core.sv @@
// self-checking testbench for the middle insert queue core
`timescale 1ns / 1ps
module tb_middle_insert_queue_core;

  localparam logic [miq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int QUEUE_CAPACITY = 2 * miq_pkg::DEF_HALF_DEPTH;

  typedef struct packed {
    logic [miq_pkg::IN_IDENT_W-1:0] popped_ident;
    logic [miq_pkg::STATUS_W-1:0]   status;
  } queue_result_t;

  typedef struct {
    logic [miq_pkg::KIND_W-1:0]     kind;
    logic [miq_pkg::IN_IDENT_W-1:0] ident;
    bit                             fixed;
    bit                             fixed_has;
    logic [miq_pkg::STATUS_W-1:0]   fixed_status;
    logic [miq_pkg::IN_IDENT_W-1:0] fixed_ident;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 30;
  int   recv_stall_pct = 88;
  bit   failed = 1'b0;
  int   full_rejects = 0;

  logic [miq_pkg::IN_IDENT_W-1:0] front_half[$];
  logic [miq_pkg::IN_IDENT_W-1:0] back_half[$];
  queue_result_t                  pending_results[$];

  request_row_t directed_rows [25] = '{
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_EMPTY, 16'h0000},
    '{KIND_UNUSED,        16'hFFFF, 1'b1, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_TAIL, 16'h0000, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_TAIL, 16'hFFFF, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_MID,  16'hAAAA, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_MID,  16'h5555, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_TAIL, 16'h1234, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_MID,  16'h8001, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'hFFFF, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_EMPTY, 16'h0000},
    '{KIND_UNUSED,        16'h0000, 1'b1, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_MID,  16'h0001, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_OK,    16'h0001},
    '{miq_pkg::KIND_TAIL, 16'h8000, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_OK,    16'h8000},
    '{miq_pkg::KIND_MID,  16'hFFFF, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_TAIL, 16'h7FFF, 1'b0, 1'b0, miq_pkg::STATUS_OK,    16'h0000},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_OK,    16'hFFFF},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_OK,    16'h7FFF},
    '{miq_pkg::KIND_POP,  16'h0000, 1'b1, 1'b1, miq_pkg::STATUS_EMPTY, 16'h0000}
  };

  miq_in_if  in_chan ();
  miq_out_if out_chan ();

  middle_insert_queue_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // applies one request to the two half queues, returns 1 when it gives a result
  function automatic bit apply_queue_request(input logic [miq_pkg::KIND_W-1:0] kind,
                                             input logic [miq_pkg::IN_IDENT_W-1:0] ident,
                                             output queue_result_t res);
    int total;
    logic [miq_pkg::IN_IDENT_W-1:0] moved;
    res = '0;
    total = front_half.size() + back_half.size();
    case (kind) inside
      miq_pkg::KIND_TAIL, miq_pkg::KIND_MID: begin
        if (total >= QUEUE_CAPACITY) begin
          res.status = miq_pkg::STATUS_FULL;
          full_rejects++;
          return 1'b1;
        end
        if (kind == miq_pkg::KIND_TAIL) begin
          if (back_half.size() == front_half.size()) begin
            if (back_half.size() == 0) begin
              front_half.push_back(ident);
            end else begin
              moved = back_half.pop_front();
              front_half.push_back(moved);
              back_half.push_back(ident);
            end
          end else begin
            back_half.push_back(ident);
          end
        end else if (front_half.size() == back_half.size() + 1) begin
          back_half.push_front(ident);
        end else begin
          front_half.push_back(ident);
        end
        return 1'b0;
      end
      miq_pkg::KIND_POP: begin
        if (front_half.size() == 0) begin
          res.status = miq_pkg::STATUS_EMPTY;
          return 1'b1;
        end
        res.popped_ident = front_half.pop_front();
        res.status = miq_pkg::STATUS_OK;
        if (back_half.size() > front_half.size()) begin
          moved = back_half.pop_front();
          front_half.push_back(moved);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_request(input logic [miq_pkg::KIND_W-1:0] kind,
                              input logic [miq_pkg::IN_IDENT_W-1:0] ident,
                              input bit fixed, input bit fixed_has,
                              input queue_result_t fixed_res);
    queue_result_t res;
    bit has_result;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.kind  = kind;
    in_chan.ident = ident;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    has_result = apply_queue_request(kind, ident, res);
    if (fixed) begin
      has_result = fixed_has;
      res = fixed_res;
    end
    if (has_result) pending_results.push_back(res);
  endtask

  task automatic send_random_request(input int pop_pct);
    int pick;
    logic [miq_pkg::KIND_W-1:0] kind;
    pick = $urandom_range(99);
    if (pick < 3) begin
      kind = KIND_UNUSED;
    end else if (pick < 3 + pop_pct) begin
      kind = miq_pkg::KIND_POP;
    end else if ($urandom_range(1) == 0) begin
      kind = miq_pkg::KIND_TAIL;
    end else begin
      kind = miq_pkg::KIND_MID;
    end
    send_request(kind, miq_pkg::IN_IDENT_W'($urandom), 1'b0, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: popped_ident %h status %0d",
               out_chan.popped_ident, out_chan.status);
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_chan.status);
          failed = 1'b1;
        end
        if (out_chan.popped_ident !== want.popped_ident) begin
          $error("popped_ident: expected %h, actual %h",
                 want.popped_ident, out_chan.popped_ident);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    queue_result_t fixed_res;
    in_chan.valid  = 1'b0;
    in_chan.kind   = miq_pkg::KIND_TAIL;
    in_chan.ident  = '0;
    out_chan.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      fixed_res.popped_ident = directed_rows[i].fixed_ident;
      fixed_res.status       = directed_rows[i].fixed_status;
      send_request(directed_rows[i].kind, directed_rows[i].ident, directed_rows[i].fixed,
                   directed_rows[i].fixed_has, fixed_res);
    end

    // short queue, frequent empty pops
    repeat (300) send_random_request(45);

    // fill to capacity and keep pushing into the full queue
    send_idle_pct  = 88;
    recv_stall_pct = 30;
    while (full_rejects < 20) send_random_request(4);

    // drain from deep queue, back to back
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (300) send_random_request(80);

    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
